// ===== hw/rtl/risc16_decode_and_branch_resolve_defines.svh =====
// Assertion macros for the risc16 decode and branch resolve block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RISC16_DECODE_AND_BRANCH_RESOLVE_DEFINES_SVH
`define RISC16_DECODE_AND_BRANCH_RESOLVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define R16DB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define R16DB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/r16db_pkg.sv =====
// Shared types and codes for the risc16 decode and branch resolve block.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package r16db_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int REG_W      = 4;
  localparam int FLAGS_W    = 3;
  localparam int CTL_W      = 5;
  localparam int AOP_W      = 3;

  // Major opcodes, bits 15:12
  localparam logic [3:0] OP_RR    = 4'h0;
  localparam logic [3:0] OP_ANDI  = 4'h1;
  localparam logic [3:0] OP_ORI   = 4'h2;
  localparam logic [3:0] OP_XORI  = 4'h3;
  localparam logic [3:0] OP_MEMJ  = 4'h4;
  localparam logic [3:0] OP_ADDI  = 4'h5;
  localparam logic [3:0] OP_SHIFT = 4'h8;
  localparam logic [3:0] OP_SUBI  = 4'h9;
  localparam logic [3:0] OP_CMPI  = 4'hB;
  localparam logic [3:0] OP_BCOND = 4'hC;
  localparam logic [3:0] OP_MOVI  = 4'hD;
  localparam logic [3:0] OP_LUI   = 4'hF;

  // Extensions, bits 7:4, register-register group
  localparam logic [3:0] RR_AND = 4'h1;
  localparam logic [3:0] RR_OR  = 4'h2;
  localparam logic [3:0] RR_XOR = 4'h3;
  localparam logic [3:0] RR_ADD = 4'h5;
  localparam logic [3:0] RR_SUB = 4'h9;
  localparam logic [3:0] RR_CMP = 4'hB;
  localparam logic [3:0] RR_MOV = 4'hD;

  // Extensions, shift group
  localparam logic [3:0] SH_LSHI0 = 4'h0;
  localparam logic [3:0] SH_LSHI1 = 4'h1;
  localparam logic [3:0] SH_ASHI0 = 4'h2;
  localparam logic [3:0] SH_ASHI1 = 4'h3;
  localparam logic [3:0] SH_LSH   = 4'h4;
  localparam logic [3:0] SH_ASH   = 4'h6;

  // Extensions, memory and jump group
  localparam logic [3:0] MJ_LOAD  = 4'h0;
  localparam logic [3:0] MJ_STOR  = 4'h4;
  localparam logic [3:0] MJ_JAL   = 4'h8;
  localparam logic [3:0] MJ_JCOND = 4'hC;

  // ALU control lines c1..c5
  localparam logic [CTL_W-1:0] CTL_NONE  = 5'b00000;
  localparam logic [CTL_W-1:0] CTL_ADDR  = 5'b00001;
  localparam logic [CTL_W-1:0] CTL_MOVE  = 5'b00010;
  localparam logic [CTL_W-1:0] CTL_IMM   = 5'b00100;
  localparam logic [CTL_W-1:0] CTL_SUB   = 5'b01000;
  localparam logic [CTL_W-1:0] CTL_ARITH = 5'b10000;

  // ALU operation codes
  localparam logic [AOP_W-1:0] ALU_AND    = 3'd0;
  localparam logic [AOP_W-1:0] ALU_OR     = 3'd1;
  localparam logic [AOP_W-1:0] ALU_XOR    = 3'd2;
  localparam logic [AOP_W-1:0] ALU_ADD    = 3'd3;
  localparam logic [AOP_W-1:0] ALU_SHIFT  = 3'd4;
  localparam logic [AOP_W-1:0] ALU_MEM    = 3'd5;
  localparam logic [AOP_W-1:0] ALU_BRANCH = 3'd7;

  // Register read enables
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_SRC  = 2'd1;
  localparam logic [1:0] RD_DST  = 2'd2;
  localparam logic [1:0] RD_BOTH = 2'd3;

  // Writeback side input
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_PC   = 2'd1;
  localparam logic [1:0] SIDE_MEM  = 2'd2;

  // Condition codes
  localparam logic [3:0] COND_EQ     = 4'h0;
  localparam logic [3:0] COND_NE     = 4'h1;
  localparam logic [3:0] COND_CS     = 4'h2;
  localparam logic [3:0] COND_CC     = 4'h3;
  localparam logic [3:0] COND_GT     = 4'h6;
  localparam logic [3:0] COND_LE     = 4'h7;
  localparam logic [3:0] COND_LT     = 4'hC;
  localparam logic [3:0] COND_GE     = 4'hD;
  localparam logic [3:0] COND_ALWAYS = 4'hE;
  localparam logic [3:0] COND_NEVER  = 4'hF;

  // Flag bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_G = 1;
  localparam int FLAG_Z = 2;

  typedef enum logic {
    TGT_REL,
    TGT_ALU
  } tgt_sel_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] instruction;
    logic [DATA_WIDTH-1:0] pc_now;
    logic [DATA_WIDTH-1:0] alu_result;
    logic [FLAGS_W-1:0]    flags;
  } in_item_t;

  typedef struct packed {
    logic [REG_W-1:0]      src_reg;
    logic [REG_W-1:0]      dst_reg;
    logic [1:0]            read_enables;
    logic                  reg_write;
    logic                  mem_write;
    logic [CTL_W-1:0]      alu_controls;
    logic [AOP_W-1:0]      alu_opcode;
    logic [DATA_WIDTH-1:0] alu_immediate;
    logic [1:0]            side_source;
    logic                  branch_taken;
    logic [DATA_WIDTH-1:0] next_pc;
  } out_item_t;

  // Branch control handed from decode to branch resolve
  typedef struct packed {
    logic [3:0] cond;
    tgt_sel_t   tgt_sel;
  } br_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/r16db_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on r16db_pkg for field widths.
`default_nettype none

interface r16db_in_if;
  logic                              valid;
  logic                              ready;
  logic [r16db_pkg::DATA_WIDTH-1:0]  instruction;
  logic [r16db_pkg::DATA_WIDTH-1:0]  pc_now;
  logic [r16db_pkg::DATA_WIDTH-1:0]  alu_result;
  logic [r16db_pkg::FLAGS_W-1:0]     flags;

  modport source (output valid, output instruction, output pc_now, output alu_result,
                  output flags, input ready);
  modport sink   (input valid, input instruction, input pc_now, input alu_result,
                  input flags, output ready);
endinterface

interface r16db_out_if;
  logic                              valid;
  logic                              ready;
  logic [r16db_pkg::REG_W-1:0]       src_reg;
  logic [r16db_pkg::REG_W-1:0]       dst_reg;
  logic [1:0]                        read_enables;
  logic                              reg_write;
  logic                              mem_write;
  logic [r16db_pkg::CTL_W-1:0]       alu_controls;
  logic [r16db_pkg::AOP_W-1:0]       alu_opcode;
  logic [r16db_pkg::DATA_WIDTH-1:0]  alu_immediate;
  logic [1:0]                        side_source;
  logic                              branch_taken;
  logic [r16db_pkg::DATA_WIDTH-1:0]  next_pc;

  modport source (output valid, output src_reg, output dst_reg, output read_enables,
                  output reg_write, output mem_write, output alu_controls,
                  output alu_opcode, output alu_immediate, output side_source,
                  output branch_taken, output next_pc, input ready);
  modport sink   (input valid, input src_reg, input dst_reg, input read_enables,
                  input reg_write, input mem_write, input alu_controls,
                  input alu_opcode, input alu_immediate, input side_source,
                  input branch_taken, input next_pc, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/r16db_decode.sv =====
// Instruction decoder: register addresses, enables, ALU controls and immediate.
// Depends on r16db_pkg; feeds branch control to r16db_branch.
`default_nettype none

module r16db_decode (
  input  wire logic [r16db_pkg::DATA_WIDTH-1:0] instruction,
  output r16db_pkg::out_item_t                  dec,
  output r16db_pkg::br_ctrl_t                   br
);

  logic [3:0] op;
  logic [3:0] ext;
  logic [3:0] dst;
  logic [7:0] imm8;

  assign op   = instruction[15:12];
  assign dst  = instruction[11:8];
  assign ext  = instruction[7:4];
  assign imm8 = instruction[7:0];

  always_comb begin
    dec               = '0;
    dec.src_reg       = instruction[3:0];
    dec.dst_reg       = dst;
    dec.read_enables  = r16db_pkg::RD_NONE;
    dec.alu_controls  = r16db_pkg::CTL_NONE;
    dec.alu_opcode    = r16db_pkg::ALU_XOR;
    dec.alu_immediate = {8'h00, imm8};
    dec.side_source   = r16db_pkg::SIDE_NONE;
    br.cond           = r16db_pkg::COND_NEVER;
    br.tgt_sel        = r16db_pkg::TGT_REL;

    unique case (op) inside
      r16db_pkg::OP_RR: begin
        unique case (ext) inside
          r16db_pkg::RR_ADD, r16db_pkg::RR_SUB, r16db_pkg::RR_CMP: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.reg_write    = (ext != r16db_pkg::RR_CMP);
            dec.alu_controls = (ext == r16db_pkg::RR_ADD) ? r16db_pkg::CTL_NONE
                                                          : r16db_pkg::CTL_SUB;
            dec.alu_opcode   = r16db_pkg::ALU_ADD;
          end
          r16db_pkg::RR_AND: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.reg_write    = 1'b1;
            dec.alu_opcode   = r16db_pkg::ALU_AND;
          end
          r16db_pkg::RR_OR: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.reg_write    = 1'b1;
            dec.alu_opcode   = r16db_pkg::ALU_OR;
          end
          r16db_pkg::RR_XOR: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.reg_write    = 1'b1;
            dec.alu_opcode   = r16db_pkg::ALU_XOR;
          end
          r16db_pkg::RR_MOV: begin
            dec.read_enables = r16db_pkg::RD_SRC;
            dec.reg_write    = 1'b1;
            dec.alu_controls = r16db_pkg::CTL_MOVE;
            dec.alu_opcode   = r16db_pkg::ALU_ADD;
          end
          default: ;
        endcase
      end
      r16db_pkg::OP_ADDI, r16db_pkg::OP_SUBI, r16db_pkg::OP_CMPI: begin
        dec.read_enables  = r16db_pkg::RD_DST;
        dec.reg_write     = (op != r16db_pkg::OP_CMPI);
        dec.alu_controls  = (op == r16db_pkg::OP_ADDI) ? r16db_pkg::CTL_IMM
                          : (r16db_pkg::CTL_IMM | r16db_pkg::CTL_SUB);
        dec.alu_opcode    = r16db_pkg::ALU_ADD;
        dec.alu_immediate = {{8{imm8[7]}}, imm8};
      end
      r16db_pkg::OP_ANDI: begin
        dec.read_enables = r16db_pkg::RD_DST;
        dec.reg_write    = 1'b1;
        dec.alu_controls = r16db_pkg::CTL_IMM;
        dec.alu_opcode   = r16db_pkg::ALU_AND;
      end
      r16db_pkg::OP_ORI: begin
        dec.read_enables = r16db_pkg::RD_DST;
        dec.reg_write    = 1'b1;
        dec.alu_controls = r16db_pkg::CTL_IMM;
        dec.alu_opcode   = r16db_pkg::ALU_OR;
      end
      r16db_pkg::OP_XORI: begin
        dec.read_enables = r16db_pkg::RD_DST;
        dec.reg_write    = 1'b1;
        dec.alu_controls = r16db_pkg::CTL_IMM;
        dec.alu_opcode   = r16db_pkg::ALU_XOR;
      end
      r16db_pkg::OP_MOVI, r16db_pkg::OP_LUI: begin
        dec.reg_write    = 1'b1;
        dec.alu_controls = r16db_pkg::CTL_IMM | r16db_pkg::CTL_MOVE;
        dec.alu_opcode   = r16db_pkg::ALU_ADD;
        if (op == r16db_pkg::OP_LUI) begin
          dec.alu_immediate = {imm8, 8'h00};
        end
      end
      r16db_pkg::OP_SHIFT: begin
        unique case (ext) inside
          r16db_pkg::SH_LSH, r16db_pkg::SH_ASH: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.reg_write    = 1'b1;
            dec.alu_controls = (ext == r16db_pkg::SH_ASH) ? r16db_pkg::CTL_ARITH
                                                          : r16db_pkg::CTL_NONE;
            dec.alu_opcode   = r16db_pkg::ALU_SHIFT;
          end
          r16db_pkg::SH_LSHI0, r16db_pkg::SH_LSHI1,
          r16db_pkg::SH_ASHI0, r16db_pkg::SH_ASHI1: begin
            dec.read_enables  = r16db_pkg::RD_DST;
            dec.reg_write     = 1'b1;
            dec.alu_controls  = ext[1] ? (r16db_pkg::CTL_IMM | r16db_pkg::CTL_ARITH)
                                       : r16db_pkg::CTL_IMM;
            dec.alu_opcode    = r16db_pkg::ALU_SHIFT;
            // 5-bit signed count; its top bit is the low ext bit, so it is part of the value
            dec.alu_immediate = {{11{imm8[4]}}, imm8[4:0]};
          end
          default: ;
        endcase
      end
      r16db_pkg::OP_MEMJ: begin
        unique case (ext) inside
          r16db_pkg::MJ_LOAD: begin
            dec.read_enables = r16db_pkg::RD_SRC;
            dec.reg_write    = 1'b1;
            dec.alu_controls = r16db_pkg::CTL_ADDR;
            dec.alu_opcode   = r16db_pkg::ALU_MEM;
            dec.side_source  = r16db_pkg::SIDE_MEM;
          end
          r16db_pkg::MJ_STOR: begin
            dec.read_enables = r16db_pkg::RD_BOTH;
            dec.mem_write    = 1'b1;
            dec.alu_controls = r16db_pkg::CTL_ADDR;
            dec.alu_opcode   = r16db_pkg::ALU_MEM;
          end
          r16db_pkg::MJ_JCOND: begin
            dec.read_enables = r16db_pkg::RD_SRC;
            dec.alu_controls = r16db_pkg::CTL_ADDR;
            dec.alu_opcode   = r16db_pkg::ALU_BRANCH;
            br.cond          = dst;
            br.tgt_sel       = r16db_pkg::TGT_ALU;
          end
          r16db_pkg::MJ_JAL: begin
            dec.read_enables = r16db_pkg::RD_SRC;
            dec.reg_write    = 1'b1;
            dec.alu_controls = r16db_pkg::CTL_ADDR;
            dec.alu_opcode   = r16db_pkg::ALU_BRANCH;
            dec.side_source  = r16db_pkg::SIDE_PC;
            br.cond          = r16db_pkg::COND_ALWAYS;
            br.tgt_sel       = r16db_pkg::TGT_ALU;
          end
          default: ;
        endcase
      end
      r16db_pkg::OP_BCOND: begin
        dec.alu_controls = r16db_pkg::CTL_IMM;
        dec.alu_opcode   = r16db_pkg::ALU_BRANCH;
        br.cond          = dst;
        br.tgt_sel       = r16db_pkg::TGT_REL;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/r16db_branch.sv =====
// Branch resolver: evaluates the condition against the flags, picks next pc.
// Depends on r16db_pkg; takes branch control from r16db_decode.
`default_nettype none

module r16db_branch (
  input  wire logic [r16db_pkg::DATA_WIDTH-1:0] instruction,
  input  wire logic [r16db_pkg::DATA_WIDTH-1:0] pc_now,
  input  wire logic [r16db_pkg::DATA_WIDTH-1:0] alu_result,
  input  wire logic [r16db_pkg::FLAGS_W-1:0]    flags,
  input  r16db_pkg::br_ctrl_t                   br,
  output logic                                  branch_taken,
  output logic [r16db_pkg::DATA_WIDTH-1:0]      next_pc
);

  logic                             c_flag;
  logic                             g_flag;
  logic                             z_flag;
  logic [r16db_pkg::DATA_WIDTH-1:0] disp;
  logic [r16db_pkg::DATA_WIDTH-1:0] target;

  assign c_flag = flags[r16db_pkg::FLAG_C];
  assign g_flag = flags[r16db_pkg::FLAG_G];
  assign z_flag = flags[r16db_pkg::FLAG_Z];

  always_comb begin
    unique case (br.cond)
      r16db_pkg::COND_EQ:     branch_taken = z_flag;
      r16db_pkg::COND_NE:     branch_taken = !z_flag;
      r16db_pkg::COND_CS:     branch_taken = c_flag;
      r16db_pkg::COND_CC:     branch_taken = !c_flag;
      r16db_pkg::COND_GT:     branch_taken = g_flag;
      r16db_pkg::COND_LE:     branch_taken = !g_flag;
      r16db_pkg::COND_LT:     branch_taken = !g_flag && !z_flag;
      r16db_pkg::COND_GE:     branch_taken = z_flag || g_flag;
      r16db_pkg::COND_ALWAYS: branch_taken = 1'b1;
      default:                branch_taken = 1'b0;
    endcase
  end

  // Signed 8-bit displacement relative to this instruction
  assign disp   = {{(r16db_pkg::DATA_WIDTH-8){instruction[7]}}, instruction[7:0]};
  assign target = (br.tgt_sel == r16db_pkg::TGT_ALU) ? alu_result : (pc_now + disp);

  assign next_pc = branch_taken ? target
                 : (pc_now + {{(r16db_pkg::DATA_WIDTH-1){1'b0}}, 1'b1});

endmodule

`default_nettype wire

// ===== hw/rtl/risc16_decode_and_branch_resolve.sv =====
// Top level: input register, decode and branch resolve, result register.
// Depends on r16db_pkg, r16db_if, r16db_decode, r16db_branch and the defines header.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+------------------------------------
//   in_ch   | in  | in_ch.valid / in_ch.ready  | instruction, pc_now, alu_result, flags
//   out_ch  | out | out_ch.valid / out_ch.ready| decoded fields, branch_taken, next_pc
//
// An item moves from acceptance through the input register and then the result register.
// Each stage advances when the stage after it can take its item, so one item is
// accepted and one result delivered every cycle while out_ch.ready stays high.
// Synchronous active-low reset empties both stages. A stall on out_ch holds the
// result register and backs up into the input register, then drops in_ch.ready.
`default_nettype none
`include "risc16_decode_and_branch_resolve_defines.svh"

module risc16_decode_and_branch_resolve (
  input  wire logic  clk,
  input  wire logic  rst_n,
  r16db_in_if.sink   in_ch,
  r16db_out_if.source out_ch
);

  logic                 s1_v_r;
  logic                 s1_v_nxt;
  r16db_pkg::in_item_t  s1_item_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  r16db_pkg::out_item_t out_item_r;
  r16db_pkg::out_item_t res_item;
  r16db_pkg::out_item_t dec;
  r16db_pkg::br_ctrl_t  br;
  logic                 s2_open;
  logic                 s1_open;
  logic                 in_fire;
  logic                 adv;
  logic                 taken;
  logic [r16db_pkg::DATA_WIDTH-1:0] npc;

  assign s2_open = !out_v_r || out_ch.ready;
  assign s1_open = !s1_v_r || s2_open;
  assign in_fire = in_ch.valid && s1_open;
  assign adv     = s1_v_r && s2_open;

  assign in_ch.ready = s1_open;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_open) begin
      s1_v_nxt = in_ch.valid;
    end
    out_v_nxt = out_v_r;
    if (s2_open) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.instruction <= in_ch.instruction;
      s1_item_r.pc_now      <= in_ch.pc_now;
      s1_item_r.alu_result  <= in_ch.alu_result;
      s1_item_r.flags       <= in_ch.flags;
    end
    if (adv) begin
      out_item_r <= res_item;
    end
  end

  r16db_decode u_decode (
    .instruction (s1_item_r.instruction),
    .dec         (dec),
    .br          (br)
  );

  r16db_branch u_branch (
    .instruction  (s1_item_r.instruction),
    .pc_now       (s1_item_r.pc_now),
    .alu_result   (s1_item_r.alu_result),
    .flags        (s1_item_r.flags),
    .br           (br),
    .branch_taken (taken),
    .next_pc      (npc)
  );

  always_comb begin
    res_item              = dec;
    res_item.branch_taken = taken;
    res_item.next_pc      = npc;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.src_reg       = out_item_r.src_reg;
  assign out_ch.dst_reg       = out_item_r.dst_reg;
  assign out_ch.read_enables  = out_item_r.read_enables;
  assign out_ch.reg_write     = out_item_r.reg_write;
  assign out_ch.mem_write     = out_item_r.mem_write;
  assign out_ch.alu_controls  = out_item_r.alu_controls;
  assign out_ch.alu_opcode    = out_item_r.alu_opcode;
  assign out_ch.alu_immediate = out_item_r.alu_immediate;
  assign out_ch.side_source   = out_item_r.side_source;
  assign out_ch.branch_taken  = out_item_r.branch_taken;
  assign out_ch.next_pc       = out_item_r.next_pc;

  `R16DB_ASSERT_NEXT(a_accept_fills_s1, in_fire, s1_v_r, "accepted item not held in input stage")
  `R16DB_ASSERT_NEXT(a_stall_keeps_s1, s1_v_r && !s2_open, s1_v_r, "stalled item dropped")
  `R16DB_ASSERT_NOW(a_store_is_mem, out_v_r && out_ch.mem_write, out_ch.alu_opcode == r16db_pkg::ALU_MEM, "store without memory opcode")
  `R16DB_ASSERT_NOW(a_jal_taken, out_v_r && out_ch.side_source == r16db_pkg::SIDE_PC, out_ch.branch_taken, "link without taken jump")

endmodule

`default_nettype wire
